// ===== rtl/core/mbwrf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbwrf_pkg
// Types, constants and the CRC-16/MODBUS byte step shared by the framer.
// ----------------------------------------------------------------------------
package mbwrf_pkg;

	localparam int FRAME_LEN   = 8;
	localparam int HDR_LEN     = 6;
	localparam int BYTE_CNT_W  = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 8;

	localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
	localparam logic [7:0]  REG_ADDR_HI       = 8'h00;
	localparam logic [15:0] CRC_INIT          = 16'hFFFF;
	localparam logic [15:0] CRC_POLY          = 16'hA001;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDRESS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COMMAND_DELAY = 1'd1;

	// frame byte positions used by the front and back end
	localparam logic [BYTE_CNT_W-1:0] POS_LAST_HDR = 3'd5;
	localparam logic [BYTE_CNT_W-1:0] POS_CRC_LO   = 3'd6;
	localparam logic [BYTE_CNT_W-1:0] POS_CRC_HI   = 3'd7;

	typedef struct packed {
		logic [7:0] relay_index;
		logic [7:0] relay_command;
	} req_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} rsp_t;

	// one framed request: header bytes plus finished CRC
	typedef struct packed {
		logic [HDR_LEN-1:0][7:0] hdr;
		logic [15:0]             crc;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// reflected CRC-16 over one byte, LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
			input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/modbus_write_register_framer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_write_register_framer_top
// Modbus RTU write-single-register frame builder with CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// Usage:
//   A request (relay index, command) is taken at a clock edge where start is
//   high and busy is low. It yields eight result bytes: slave address, 0x06,
//   0x00, relay index, command, delay, CRC low, CRC high. Each byte is shown
//   for one cycle with result_strobe high; last_byte marks the CRC high byte.
//   The receiver cannot stall; bytes of back-to-back requests run gap-free.
//   Path: with the back end idle, the first byte reaches the result ports
//   after the front end runs the CRC over the six header bytes (one header
//   byte per cycle), the frame queue stores the finished frame and the back
//   end loads it. Pacing: the sustained request rate is set by the one-byte
//   result channel; a two-entry frame queue lets the front take the next
//   request while the back end is still emitting. busy stays high while the
//   CRC runs or a finished frame waits for queue space.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 slave address, 1 delay byte); write only while idle.
//   Reset: slave address 1, delay 0, queue empty, no request in flight.
// ----------------------------------------------------------------------------
module modbus_write_register_framer_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [mbwrf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mbwrf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                             start,
	input  wire mbwrf_pkg::req_t                  req,
	output logic                                  busy,
	output logic                                  result_strobe,
	output mbwrf_pkg::rsp_t                       result
);

	mbwrf_pkg::q_stat_t q_stat;
	mbwrf_pkg::frame_t  push_frame;
	mbwrf_pkg::frame_t  head;
	logic               push;
	logic               pop;

	mbwrf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.start      (start),
		.req        (req),
		.busy       (busy),
		.q_stat     (q_stat),
		.push       (push),
		.push_frame (push_frame)
	);

	mbwrf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	mbwrf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_stat        (q_stat),
		.pop           (pop),
		.result_strobe (result_strobe),
		.result        (result)
	);

endmodule
`default_nettype wire

// ===== rtl/core/mbwrf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbwrf_front
// Holds configuration, accepts requests, builds header and runs the CRC.
// ----------------------------------------------------------------------------
module mbwrf_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [mbwrf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mbwrf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                             start,
	input  wire mbwrf_pkg::req_t                  req,
	output logic                                  busy,
	input  wire mbwrf_pkg::q_stat_t               q_stat,
	output logic                                  push,
	output mbwrf_pkg::frame_t                     push_frame
);

	logic [7:0] slave_address_q;
	logic [7:0] command_delay_q;
	logic       active_q;
	logic       pending_q;
	logic [mbwrf_pkg::BYTE_CNT_W-1:0] cnt_q;
	logic [mbwrf_pkg::HDR_LEN-1:0][7:0] hdr_q;
	logic [15:0] crc_q;
	logic [15:0] crc_next;
	logic        last_step;
	logic        accept;

	assign busy      = active_q | pending_q;
	assign accept    = start & ~busy;
	assign crc_next  = mbwrf_pkg::crc_byte(crc_q, hdr_q[cnt_q]);
	assign last_step = active_q & (cnt_q == mbwrf_pkg::POS_LAST_HDR);

	// finished frame goes straight to the queue unless it is full
	assign push = (last_step | pending_q) & ~q_stat.full;
	assign push_frame.hdr = hdr_q;
	assign push_frame.crc = pending_q ? crc_q : crc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= 8'd1;
			command_delay_q <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mbwrf_pkg::REG_SLAVE_ADDRESS: slave_address_q <= cfg_data;
				mbwrf_pkg::REG_COMMAND_DELAY: command_delay_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			pending_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (accept) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					active_q  <= 1'b0;
					pending_q <= q_stat.full;
				end
			end else if (pending_q && !q_stat.full) begin
				pending_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hdr_q[0] <= slave_address_q;
			hdr_q[1] <= mbwrf_pkg::FUNC_WRITE_SINGLE;
			hdr_q[2] <= mbwrf_pkg::REG_ADDR_HI;
			hdr_q[3] <= req.relay_index;
			hdr_q[4] <= req.relay_command;
			hdr_q[5] <= command_delay_q;
			crc_q    <= mbwrf_pkg::CRC_INIT;
		end else if (active_q) begin
			crc_q <= crc_next;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/mbwrf_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbwrf_queue
// Two-entry queue of framed requests between front and back end.
// ----------------------------------------------------------------------------
module mbwrf_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire mbwrf_pkg::frame_t  push_frame,
	input  wire logic               pop,
	output mbwrf_pkg::frame_t       head,
	output mbwrf_pkg::q_stat_t      q_stat
);

	mbwrf_pkg::frame_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign q_stat.full  = count_q == 2'd2;
	assign q_stat.empty = count_q == 2'd0;
	assign do_push = push & ~q_stat.full;
	assign do_pop  = pop & ~q_stat.empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/mbwrf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbwrf_back
// Serializes one queued frame into eight result bytes, one per cycle.
// ----------------------------------------------------------------------------
module mbwrf_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mbwrf_pkg::frame_t  head,
	input  wire mbwrf_pkg::q_stat_t q_stat,
	output logic                    pop,
	output logic                    result_strobe,
	output mbwrf_pkg::rsp_t         result
);

	logic                              active_q;
	logic [mbwrf_pkg::BYTE_CNT_W-1:0]  cnt_q;
	mbwrf_pkg::frame_t                 frame_q;
	logic                              at_last;

	assign at_last = cnt_q == mbwrf_pkg::POS_CRC_HI;
	// next frame loads during the last byte so bytes run without a gap
	assign pop = ~q_stat.empty & (~active_q | at_last);

	assign result_strobe    = active_q;
	assign result.last_byte = at_last;

	always_comb begin
		unique case (cnt_q)
			mbwrf_pkg::POS_CRC_LO: result.frame_byte = frame_q.crc[7:0];
			mbwrf_pkg::POS_CRC_HI: result.frame_byte = frame_q.crc[15:8];
			default:               result.frame_byte = frame_q.hdr[cnt_q];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (active_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (at_last) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			frame_q <= head;
		end
	end

endmodule
`default_nettype wire
